/* src/tspg_pkg.sv */
package tspg_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_START_DELAY     = 2'd0,
      CSR_MIN_DELAY       = 2'd1,
      CSR_DELAY_CHANGE    = 2'd2,
      CSR_DIRECTION_LEVEL = 2'd3
   } csr_index_type;

   localparam int unsigned STEP_COUNT_WIDTH   = 16;
   localparam int unsigned CFG_DELAY_WIDTH    = 16;
   localparam int unsigned CFG_CHANGE_WIDTH   = 8;
   localparam int unsigned CSR_DATA_WIDTH     = 16;

   localparam logic [CFG_DELAY_WIDTH-1:0]  START_DELAY_RESET  = 16'd2000;
   localparam logic [CFG_DELAY_WIDTH-1:0]  MIN_DELAY_RESET    = 16'd500;
   localparam logic [CFG_CHANGE_WIDTH-1:0] DELAY_CHANGE_RESET = 8'd5;
   localparam logic                        DIRECTION_RESET    = 1'b1;

   // Input word opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic [CFG_DELAY_WIDTH-1:0]  start_delay;
      logic [CFG_DELAY_WIDTH-1:0]  min_delay;
      logic [CFG_CHANGE_WIDTH-1:0] delay_change;
      logic                        direction_level;
   } cfg_type;

   typedef struct packed {
      logic step_level;
      logic dir_level;
      logic busy_res;
      logic move_done;
   } rsp_type;

endpackage

/* src/tspg_ramp.sv */
// Half-period update applied when a pulse completes.
module tspg_ramp #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic [COUNT_WIDTH-1:0]                 step_index,
   input  logic [COUNT_WIDTH-1:0]                 total_steps,
   input  logic [COUNT_WIDTH-3:0]                 ramp_steps,
   input  logic [DELAY_WIDTH-1:0]                 half_period,
   input  logic [DELAY_WIDTH-1:0]                 start_delay,
   input  logic [DELAY_WIDTH-1:0]                 min_delay,
   input  logic [tspg_pkg::CFG_CHANGE_WIDTH-1:0]  delay_change,
   output logic [DELAY_WIDTH-1:0]                 half_period_next
);

   localparam int unsigned CHG_PAD = DELAY_WIDTH + 1 - tspg_pkg::CFG_CHANGE_WIDTH;

   logic [COUNT_WIDTH-1:0] ramp_ext;
   logic [COUNT_WIDTH-1:0] decel_start;
   logic [DELAY_WIDTH:0]   hp_ext;
   logic [DELAY_WIDTH:0]   chg_ext;
   logic [DELAY_WIDTH:0]   chg_plus1;
   logic [DELAY_WIDTH:0]   rise_sum;
   logic                   accel;
   logic                   decel;

   always_comb begin
      ramp_ext    = {2'b00, ramp_steps};
      decel_start = total_steps - ramp_ext;
      hp_ext      = {1'b0, half_period};
      chg_ext     = {{CHG_PAD{1'b0}}, delay_change};
      chg_plus1   = chg_ext + {{DELAY_WIDTH{1'b0}}, 1'b1};
      rise_sum    = hp_ext + chg_ext;
      accel       = (step_index < ramp_ext) && (half_period > min_delay);
      decel       = (step_index > decel_start) && (half_period < start_delay);

      half_period_next = half_period;
      if (accel) begin
         if (hp_ext > chg_plus1) begin
            half_period_next = half_period - chg_ext[DELAY_WIDTH-1:0];
         end else begin
            half_period_next = {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
         end
      end else if (decel) begin
         // saturate at full scale
         if (rise_sum[DELAY_WIDTH]) begin
            half_period_next = {DELAY_WIDTH{1'b1}};
         end else begin
            half_period_next = rise_sum[DELAY_WIDTH-1:0];
         end
      end
   end

endmodule

/* src/tspg_core.sv */
// Move state and per-word update. State advances on each word passed in.
module tspg_core #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fire,
   input  logic                                   opcode,
   input  logic [tspg_pkg::STEP_COUNT_WIDTH-1:0]  step_count,
   input  tspg_pkg::cfg_type                      cfg,
   output tspg_pkg::rsp_type                      rsp
);

   logic                   active_ff,       active_in;
   logic [COUNT_WIDTH-1:0] total_steps_ff,  total_steps_in;
   logic [COUNT_WIDTH-3:0] ramp_steps_ff,   ramp_steps_in;
   logic [COUNT_WIDTH-1:0] step_index_ff,   step_index_in;
   logic [DELAY_WIDTH-1:0] half_period_ff,  half_period_in;
   logic [DELAY_WIDTH-1:0] tick_counter_ff, tick_counter_in;
   logic                   pulse_phase_ff,  pulse_phase_in;

   logic [COUNT_WIDTH+tspg_pkg::STEP_COUNT_WIDTH-1:0] count_ext;
   logic [DELAY_WIDTH+tspg_pkg::CFG_DELAY_WIDTH-1:0]  sd_ext;
   logic [DELAY_WIDTH+tspg_pkg::CFG_DELAY_WIDTH-1:0]  md_ext;
   logic [COUNT_WIDTH-1:0] n_val;
   logic [DELAY_WIDTH-1:0] sd_val;
   logic [DELAY_WIDTH-1:0] md_val;
   logic [DELAY_WIDTH-1:0] tick_next;
   logic [COUNT_WIDTH-1:0] index_next;
   logic [DELAY_WIDTH-1:0] hp_ramped;
   logic                   done;

   assign count_ext = {{COUNT_WIDTH{1'b0}}, step_count};
   assign sd_ext    = {{DELAY_WIDTH{1'b0}}, cfg.start_delay};
   assign md_ext    = {{DELAY_WIDTH{1'b0}}, cfg.min_delay};
   assign n_val     = count_ext[COUNT_WIDTH-1:0];
   assign sd_val    = sd_ext[DELAY_WIDTH-1:0];
   assign md_val    = md_ext[DELAY_WIDTH-1:0];

   tspg_ramp #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_ramp (
      .step_index       (step_index_ff),
      .total_steps      (total_steps_ff),
      .ramp_steps       (ramp_steps_ff),
      .half_period      (half_period_ff),
      .start_delay      (sd_val),
      .min_delay        (md_val),
      .delay_change     (cfg.delay_change),
      .half_period_next (hp_ramped)
   );

   always_comb begin
      active_in       = active_ff;
      total_steps_in  = total_steps_ff;
      ramp_steps_in   = ramp_steps_ff;
      step_index_in   = step_index_ff;
      half_period_in  = half_period_ff;
      tick_counter_in = tick_counter_ff;
      pulse_phase_in  = pulse_phase_ff;
      done            = 1'b0;
      tick_next       = tick_counter_ff + {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
      index_next      = step_index_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

      if (opcode == tspg_pkg::OP_START) begin
         // start while busy is dropped
         if (!active_ff) begin
            if (n_val == '0) begin
               done           = 1'b1;
               pulse_phase_in = 1'b0;
            end else begin
               active_in       = 1'b1;
               total_steps_in  = n_val;
               ramp_steps_in   = n_val[COUNT_WIDTH-1:2];
               step_index_in   = '0;
               half_period_in  = sd_val;
               tick_counter_in = '0;
               pulse_phase_in  = 1'b1;
            end
         end
      end else if (active_ff) begin
         tick_counter_in = tick_next;
         // wrap to zero also ends the half (zero half period)
         if ((tick_next >= half_period_ff) || (tick_next == '0)) begin
            tick_counter_in = '0;
            if (pulse_phase_ff) begin
               pulse_phase_in = 1'b0;
            end else begin
               half_period_in = hp_ramped;
               step_index_in  = index_next;
               if (index_next >= total_steps_ff) begin
                  active_in      = 1'b0;
                  done           = 1'b1;
                  pulse_phase_in = 1'b0;
               end else begin
                  pulse_phase_in = 1'b1;
               end
            end
         end
      end

      rsp.step_level = pulse_phase_in;
      rsp.dir_level  = cfg.direction_level;
      rsp.busy_res   = active_in;
      rsp.move_done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         total_steps_ff  <= '0;
         ramp_steps_ff   <= '0;
         step_index_ff   <= '0;
         half_period_ff  <= '0;
         tick_counter_ff <= '0;
         pulse_phase_ff  <= 1'b0;
      end else if (fire) begin
         active_ff       <= active_in;
         total_steps_ff  <= total_steps_in;
         ramp_steps_ff   <= ramp_steps_in;
         step_index_ff   <= step_index_in;
         half_period_ff  <= half_period_in;
         tick_counter_ff <= tick_counter_in;
         pulse_phase_ff  <= pulse_phase_in;
      end
   end

endmodule

/* src/trapezoid_step_pulse_generator_top.sv */
// Trapezoidal step pulse generator. Each input word is either a one-tick
// time step or a start command carrying the pulse count N; each word gives
// exactly one result word with the step pin level, direction pin level,
// busy flag and a done flag on the word where the last pulse ends. Pulses
// are D ticks high and D ticks low; D starts at start_delay, shrinks by
// delay_change over the first N/4 pulses (down to min_delay) and grows back
// over the last N/4. The block takes one word per clock cycle while the
// result side is not stalled; each word goes through one input register,
// then a single pass of counter/compare logic into the result register.
// The result register and the input register are separated, so one more
// word is taken while a result waits; the input stalls only when both
// hold a word and the result is stalled. A start while busy is ignored;
// N = 0 reports done at once. Configuration must be written only while no
// word is in flight; the block itself does not enforce this. A write made
// during a move applies from the next word on.
module trapezoid_step_pulse_generator_top #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input word channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [tspg_pkg::STEP_COUNT_WIDTH-1:0]  req_step_count,
   // result word channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_step_level,
   output logic                                   rsp_dir_level,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_move_done,
   // configuration write port
   input  logic                                   csr_wr_en,
   input  tspg_pkg::csr_index_type                csr_index,
   input  logic [tspg_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   tspg_pkg::cfg_type cfg_ff, cfg_in;

   // input register
   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s1_opcode_ff;
   logic [tspg_pkg::STEP_COUNT_WIDTH-1:0] s1_count_ff;

   // result register
   logic                                  rsp_valid_ff, rsp_valid_in;
   tspg_pkg::rsp_type                     rsp_ff;
   tspg_pkg::rsp_type                     core_rsp;

   logic req_accept;
   logic s1_move;
   logic fire;

   // ---------------- configuration ----------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tspg_pkg::CSR_START_DELAY:     cfg_in.start_delay = csr_wdata;
            tspg_pkg::CSR_MIN_DELAY:       cfg_in.min_delay   = csr_wdata;
            tspg_pkg::CSR_DELAY_CHANGE:
               cfg_in.delay_change = csr_wdata[tspg_pkg::CFG_CHANGE_WIDTH-1:0];
            tspg_pkg::CSR_DIRECTION_LEVEL: cfg_in.direction_level = csr_wdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay     <= tspg_pkg::START_DELAY_RESET;
         cfg_ff.min_delay       <= tspg_pkg::MIN_DELAY_RESET;
         cfg_ff.delay_change    <= tspg_pkg::DELAY_CHANGE_RESET;
         cfg_ff.direction_level <= tspg_pkg::DIRECTION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- handshake ----------------
   // stage 1 drains when the result register is empty or being taken
   assign s1_move    = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && s1_move;
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff <= req_opcode;
         s1_count_ff  <= req_step_count;
      end
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   // ---------------- move engine ----------------
   tspg_core #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .opcode     (s1_opcode_ff),
      .step_count (s1_count_ff),
      .cfg        (cfg_ff),
      .rsp        (core_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_level = rsp_ff.step_level;
   assign rsp_dir_level  = rsp_ff.dir_level;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_move_done  = rsp_ff.move_done;

   // ---------------- checks ----------------
   // a finished move is never reported as still busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.move_done |-> !rsp_ff.busy_res)
      else $error("move_done with busy set");

   // step pin is low whenever no move runs
   a_idle_step_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.busy_res |-> !rsp_ff.step_level)
      else $error("step high while idle");

   // a word handed to the engine always shows up as a result next cycle
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("result lost after engine update");

   // input register only pushes back when it holds a word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with free pipeline");

endmodule

/* sim/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Random part length in live words (ticks during a move, starts while idle)
   localparam int WORD_TARGET = 1400;
   // Past this many random live words both sides stop idling
   localparam int QUIET_TAIL  = 1100;
   // Cycles with no word moving on either channel before giving up
   localparam int STALL_LIMIT = 1000;

   // Directed plan: a row is either an input word or a register write.
   // Pinned rows carry levels that are obvious from the spec; the rest go
   // through the predictor.
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    opcode;
      logic [15:0]             value;    // step count for a word, data for a csr row
      tspg_pkg::csr_index_type reg_sel;
      logic                    pinned;
      tspg_pkg::rsp_type       levels;   // step, dir, busy, done
   } plan_row_type;

   localparam int PLAN_LEN = 20;

   plan_row_type plan [PLAN_LEN] = '{
      // tick right after reset: nothing moving, dir from reset value
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b0100},
      // zero-length move finishes on the spot
      '{ROW_WORD, tspg_pkg::OP_START, 16'h0000, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b0101},
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_DIRECTION_LEVEL,
        1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_START, 16'h0000, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b0001},
      // zero half period acts as one tick; largest change (upper byte dropped)
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_MIN_DELAY,    1'b0, 4'b0000},
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'hFFFF, tspg_pkg::CSR_DELAY_CHANGE, 1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_START, 16'h0003, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b1010},
      // start while busy is dropped, levels unchanged
      '{ROW_WORD, tspg_pkg::OP_START, 16'hFFFF, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b1010},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'hFFFF, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'hA5A5, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'h5A5A, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'hFFFF, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      // idle tick once the move is over
      '{ROW_WORD, tspg_pkg::OP_TICK,  16'h0000, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b0000},
      // floor above the start delay; direction write with junk upper bits
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'hFFFF, tspg_pkg::CSR_DIRECTION_LEVEL,
        1'b0, 4'b0000},
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'h0003, tspg_pkg::CSR_START_DELAY,  1'b0, 4'b0000},
      '{ROW_CSR,  tspg_pkg::OP_TICK,  16'hFFFF, tspg_pkg::CSR_MIN_DELAY,    1'b0, 4'b0000},
      '{ROW_WORD, tspg_pkg::OP_START, 16'h0001, tspg_pkg::CSR_START_DELAY,  1'b1, 4'b1110}
   };

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic                                  req_opcode = tspg_pkg::OP_TICK;
   logic [tspg_pkg::STEP_COUNT_WIDTH-1:0] req_step_count = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_step_level;
   logic                                  rsp_dir_level;
   logic                                  rsp_busy_res;
   logic                                  rsp_move_done;
   logic                                  csr_wr_en = 1'b0;
   tspg_pkg::csr_index_type               csr_index = tspg_pkg::CSR_START_DELAY;
   logic [tspg_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata = '0;

   // Predictor: register copy and move state
   tspg_pkg::cfg_type cfg = '{tspg_pkg::START_DELAY_RESET, tspg_pkg::MIN_DELAY_RESET,
                              tspg_pkg::DELAY_CHANGE_RESET, tspg_pkg::DIRECTION_RESET};
   logic        run_busy  = 1'b0;
   logic [15:0] run_total = '0;
   logic [13:0] run_ramp  = '0;
   logic [15:0] run_index = '0;
   logic [15:0] run_half  = '0;
   logic [15:0] run_ticks = '0;
   logic        run_high  = 1'b0;

   tspg_pkg::rsp_type pin_levels_due [$];   // expected result words, oldest first
   logic              pin_valid  = 1'b0;    // current word carries pinned levels
   tspg_pkg::rsp_type pin_levels = '0;

   bit          idle_on    = 1'b1;
   int          stall_left = 0;
   int          quiet      = 0;
   int          mismatches = 0;
   int          words_in   = 0;
   int          live_words = 0;
   int          results_checked = 0;
   int          moves_done = 0;
   int          csr_writes = 0;

   always #1 clock = ~clock;

   trapezoid_step_pulse_generator_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_step_count (req_step_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_step_level (rsp_step_level),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_move_done  (rsp_move_done),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Advance the move state by one accepted word and return the pin levels.
   function automatic tspg_pkg::rsp_type next_pin_levels(input logic op,
                                                         input logic [15:0] count);
      logic              done;
      logic [16:0]       raised;
      tspg_pkg::rsp_type levels;
      done = 1'b0;
      if (op == tspg_pkg::OP_START) begin
         if (!run_busy) begin
            if (count == 16'd0) begin
               done     = 1'b1;
               run_high = 1'b0;
            end else begin
               run_busy  = 1'b1;
               run_total = count;
               run_ramp  = count[15:2];
               run_index = '0;
               run_half  = cfg.start_delay;
               run_ticks = '0;
               run_high  = 1'b1;
            end
         end
      end else if (run_busy) begin
         run_ticks = run_ticks + 16'd1;
         // zero half period behaves as one; a wrapped counter also flips
         if (run_ticks >= run_half || run_ticks == 16'd0) begin
            run_ticks = '0;
            if (run_high) begin
               run_high = 1'b0;
            end else begin
               // pulse run_index just completed: ramp down early, up late
               if (run_index < run_ramp && run_half > cfg.min_delay) begin
                  if ({1'b0, run_half} > {9'd0, cfg.delay_change} + 17'd1)
                     run_half = run_half - cfg.delay_change;
                  else
                     run_half = 16'd1;
               end else if (run_index > run_total - run_ramp
                            && run_half < cfg.start_delay) begin
                  raised   = {1'b0, run_half} + cfg.delay_change;
                  run_half = raised[16] ? 16'hFFFF : raised[15:0];
               end
               run_index = run_index + 16'd1;
               if (run_index >= run_total) begin
                  run_busy = 1'b0;
                  run_high = 1'b0;
                  done     = 1'b1;
               end else begin
                  run_high = 1'b1;
               end
            end
         end
      end
      levels.step_level = run_high;
      levels.dir_level  = cfg.direction_level;
      levels.busy_res   = run_busy;
      levels.move_done  = done;
      return levels;
   endfunction

   task automatic check_field(input string field, input logic want, input logic got);
      if (got !== want) begin
         mismatches++;
         $display("%0t tb: %s mismatch, expected %0b, got %0b", $time, field, want, got);
      end
   endtask

   // Sample both channels at the rising edge: retire results first, then
   // predict the accepted input word. Also the no-progress watchdog.
   always @(posedge clock) begin : watch_ports
      tspg_pkg::rsp_type got;
      tspg_pkg::rsp_type want;
      tspg_pkg::rsp_type calc;
      logic              moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_step_level, rsp_dir_level, rsp_busy_res, rsp_move_done};
            if (pin_levels_due.size() == 0) begin
               mismatches++;
               $display("%0t tb: result word with none expected, expected none, got %b",
                        $time, got);
            end else begin
               want = pin_levels_due.pop_front();
               check_field("step_level", want.step_level, got.step_level);
               check_field("dir_level",  want.dir_level,  got.dir_level);
               check_field("busy_res",   want.busy_res,   got.busy_res);
               check_field("move_done",  want.move_done,  got.move_done);
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            words_in++;
            if (req_opcode == tspg_pkg::OP_START ? !run_busy : run_busy)
               live_words++;
            calc = next_pin_levels(req_opcode, req_step_count);
            if (calc.move_done)
               moves_done++;
            pin_levels_due.push_back(pin_valid ? pin_levels : calc);
         end
         if (moved) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
               $display("%0t tb: no progress for %0d cycles", $time, quiet);
               $display("tb: done, errors");
               $finish;
            end
         end
      end
   end

   // Result side back-pressure in random bursts
   always @(negedge clock) begin : drive_rsp_stall
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Offer one word (after an optional gap) and hold it until accepted.
   task automatic push_word(input logic op, input logic [15:0] count,
                            input logic pinned, input tspg_pkg::rsp_type levels);
      if (idle_on && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 15)) @(negedge clock);
      req_valid      = 1'b1;
      req_opcode     = op;
      req_step_count = count;
      pin_valid      = pinned;
      pin_levels     = levels;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      pin_valid = 1'b0;
   endtask

   // Wait for every expected word, then allow extra pipeline slack.
   task automatic settle();
      while (pin_levels_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_reg(input tspg_pkg::csr_index_type reg_sel,
                              input logic [15:0] data);
      csr_wr_en = 1'b1;
      csr_index = reg_sel;
      csr_wdata = data;
      case (reg_sel)
         tspg_pkg::CSR_START_DELAY:     cfg.start_delay     = data;
         tspg_pkg::CSR_MIN_DELAY:       cfg.min_delay       = data;
         tspg_pkg::CSR_DELAY_CHANGE:    cfg.delay_change    = data[7:0];
         tspg_pkg::CSR_DIRECTION_LEVEL: cfg.direction_level = data[0];
      endcase
      csr_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // New register values; delays kept small so moves stay short.
   // Upper write bits of the narrow registers carry junk.
   task automatic shuffle_settings(input bit every);
      logic [15:0] delay_val;
      logic [7:0]  change_val;
      if (every || $urandom_range(0, 1) == 0) begin
         delay_val = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
         program_reg(tspg_pkg::CSR_START_DELAY, delay_val);
      end
      if (every || $urandom_range(0, 1) == 0) begin
         delay_val = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12));
         program_reg(tspg_pkg::CSR_MIN_DELAY, delay_val);
      end
      if (every || $urandom_range(0, 1) == 0) begin
         change_val = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
         program_reg(tspg_pkg::CSR_DELAY_CHANGE, {8'($urandom), change_val});
      end
      if (every || $urandom_range(0, 1) == 0)
         program_reg(tspg_pkg::CSR_DIRECTION_LEVEL, 16'($urandom));
   endtask

   // Mostly whole moves: start while idle, ticks while busy; now and then a
   // dropped start, an idle tick or a zero-length move.
   task automatic random_word();
      logic [15:0] count;
      count = 16'($urandom);
      if (run_busy) begin
         if ($urandom_range(0, 24) == 0)
            push_word(tspg_pkg::OP_START, count, 1'b0, '0);
         else
            push_word(tspg_pkg::OP_TICK, count, 1'b0, '0);
      end else begin
         case ($urandom_range(0, 9))
            0:       push_word(tspg_pkg::OP_START, 16'd0, 1'b0, '0);
            1:       push_word(tspg_pkg::OP_TICK, count, 1'b0, '0);
            2:       push_word(tspg_pkg::OP_START, 16'($urandom_range(25, 64)), 1'b0, '0);
            default: push_word(tspg_pkg::OP_START, 16'($urandom_range(1, 24)), 1'b0, '0);
         endcase
      end
   endtask

   initial begin : stimulus
      int base;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            program_reg(plan[i].reg_sel, plan[i].value);
         end else begin
            push_word(plan[i].opcode, plan[i].value, plan[i].pinned, plan[i].levels);
         end
      end

      // run the one-pulse move with the floor above the start delay to its end
      idle_on = 1'b0;
      while (run_busy)
         push_word(tspg_pkg::OP_TICK, 16'($urandom), 1'b0, '0);
      settle();
      shuffle_settings(1'b1);

      // random moves; register changes between bursts, sometimes mid-move
      base = live_words;
      while (live_words - base < WORD_TARGET) begin
         idle_on = (live_words - base < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(20, 150))
            random_word();
         settle();
         shuffle_settings(1'b0);
      end

      settle();
      repeat (10) @(posedge clock);
      $display("tb: %0d words in, %0d results compared, %0d moves finished",
               words_in, results_checked, moves_done);
      $display("tb: %0d register writes; zero and small half periods, floor above start",
               csr_writes);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
